// File: hdl/gbte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gap buffer text editor package
// Shared constants, request codes and item types for the gap buffer editor.
// ----------------------------------------------------------------------------
package gbte_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int REQ_W        = 3;
    localparam int CHAR_W       = 8;
    localparam int AMT_W        = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PREV   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_in;
        logic [AMT_W-1:0]  amount;
        logic              run_end;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              is_empty;
        logic              last_out;
    } t_out_item;

endpackage
`default_nettype wire

// File: hdl/gbte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module gbte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: hdl/gbte_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gap buffer editor output stage
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module gbte_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire gbte_pkg::t_out_item i_item,
    output logic                     o_free,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output gbte_pkg::t_out_item      o_out_item
);
    import gbte_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: hdl/gap_buffer_text_editor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gap buffer text editor
// A line of text with a cursor, kept as two stacks in one character memory.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_item).
// Only get produces results, which leave on the output channel (o_out_valid,
// i_out_stall, o_out_item), one item per character and the last one marked,
// or for an empty text a single item marked empty and last. A request is
// taken only while the controller is idle. Every character moved across the
// cursor (closing a run, move, next, prev) is first read from the character
// memory and then written to the other stack. Get reads each character from
// the character memory, then loads it into the output stage, waiting while
// that stage is not free. A request that follows an open insert run first
// pays for closing that run.
// Reset empties the text and the cursor is set to the start; the memory
// itself is not cleared. When the receiver stalls, the output register holds
// its item and a get waits with the next character; other requests can
// still be accepted after the last result has been registered.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor #(
    parameter int CAPACITY = gbte_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gbte_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gbte_pkg::t_out_item     o_out_item
);
    import gbte_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SH_RD,
        S_SH_WR,
        S_GET_RD,
        S_GET_WR,
        S_GET_EMPTY
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_right, n_right;
    logic [CW-1:0]    r_run, n_run;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_k, n_k;
    logic             r_dir, n_dir;
    logic             r_closing, n_closing;
    logic [REQ_W-1:0] r_req, n_req;
    logic [AMT_W-1:0] r_amount, n_amount;

    logic [CW-1:0]     total;
    logic              in_acc;
    logic              ins_ok;
    logic [CW-1:0]     run_new;
    logic [CW-1:0]     close_n;
    logic [CW-1:0]     tgt;
    logic [CW-1:0]     del;
    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic [CHAR_W-1:0] ram_wr_data;
    logic              ram_re;
    logic [AW-1:0]     ram_rd_addr;
    logic [CHAR_W-1:0] ram_rd_data;
    logic              out_load;
    logic              out_free;
    t_out_item         out_item;

    assign total      = r_left + r_right;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign ins_ok     = (total != CAP_C);
    assign run_new    = r_run + CW'(ins_ok);
    assign close_n    = (r_run < r_left) ? r_run : r_left;
    assign tgt        = (r_amount > AMT_W'(total)) ? total : CW'(r_amount);
    assign del        = (r_amount > AMT_W'(r_right)) ? r_right : CW'(r_amount);

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_right     = r_right;
        n_run       = r_run;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_dir       = r_dir;
        n_closing   = r_closing;
        n_req       = r_req;
        n_amount    = r_amount;
        ram_we      = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = ram_rd_data;
        ram_re      = 1'b0;
        ram_rd_addr = '0;
        out_load    = 1'b0;
        out_item    = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_in_item.req_type;
                    n_amount = i_in_item.amount;
                    if (i_in_item.req_type == REQ_INSERT) begin
                        if (ins_ok) begin
                            ram_we      = 1'b1;
                            ram_wr_addr = AW'(r_left);
                            ram_wr_data = i_in_item.char_in;
                            n_left      = r_left + 1'b1;
                            n_run       = run_new;
                        end
                        if (i_in_item.run_end) begin
                            n_run = '0;
                            if (run_new != '0) begin
                                n_cnt     = run_new;
                                n_dir     = 1'b0;
                                n_closing = 1'b1;
                                n_state   = S_SH_RD;
                            end
                        end
                    end else if (i_in_item.req_type <= REQ_GET) begin
                        n_run = '0;
                        if (close_n != '0) begin
                            n_cnt     = close_n;
                            n_dir     = 1'b0;
                            n_closing = 1'b1;
                            n_state   = S_SH_RD;
                        end else begin
                            n_state = S_DISPATCH;
                        end
                    end
                end
            end
            S_SH_RD: begin
                ram_re      = 1'b1;
                ram_rd_addr = r_dir ? AW'(CAP_C - r_right) : AW'(r_left - 1'b1);
                n_state     = S_SH_WR;
            end
            S_SH_WR: begin
                ram_we = 1'b1;
                if (r_dir) begin
                    ram_wr_addr = AW'(r_left);
                    n_left      = r_left + 1'b1;
                    n_right     = r_right - 1'b1;
                end else begin
                    ram_wr_addr = AW'(CAP_C - r_right - 1'b1);
                    n_left      = r_left - 1'b1;
                    n_right     = r_right + 1'b1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_closing = 1'b0;
                    n_state   = (r_closing && (r_req != REQ_INSERT)) ? S_DISPATCH : S_IDLE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                case (r_req)
                    REQ_MOVE: begin
                        if (tgt > r_left) begin
                            n_dir   = 1'b1;
                            n_cnt   = tgt - r_left;
                            n_state = S_SH_RD;
                        end else if (tgt < r_left) begin
                            n_dir   = 1'b0;
                            n_cnt   = r_left - tgt;
                            n_state = S_SH_RD;
                        end
                    end
                    REQ_DELETE: begin
                        n_right = r_right - del;
                    end
                    REQ_NEXT: begin
                        if (r_right != '0) begin
                            n_dir   = 1'b1;
                            n_cnt   = CW'(1);
                            n_state = S_SH_RD;
                        end
                    end
                    REQ_PREV: begin
                        if (r_left != '0) begin
                            n_dir   = 1'b0;
                            n_cnt   = CW'(1);
                            n_state = S_SH_RD;
                        end
                    end
                    REQ_GET: begin
                        n_k     = '0;
                        n_state = (total == '0) ? S_GET_EMPTY : S_GET_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_GET_RD: begin
                ram_re      = 1'b1;
                ram_rd_addr = (r_k < r_left) ? AW'(r_k) : AW'(r_k + (CAP_C - total));
                n_state     = S_GET_WR;
            end
            S_GET_WR: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    out_item.char_out = ram_rd_data;
                    out_item.is_empty = 1'b0;
                    out_item.last_out = ((r_k + 1'b1) == total);
                    if ((r_k + 1'b1) == total) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_GET_RD;
                    end
                end
            end
            S_GET_EMPTY: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    out_item.char_out = '0;
                    out_item.is_empty = 1'b1;
                    out_item.last_out = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_amount <= n_amount;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_dir    <= n_dir;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_right   <= '0;
            r_run     <= '0;
            r_closing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_right   <= n_right;
            r_run     <= n_run;
            r_closing <= n_closing;
        end
    end

    gbte_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    gbte_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_load),
        .i_item      (out_item),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_left} + {1'b0, r_right}) <= {1'b0, CAP_C})
        else $error("Text length exceeds the capacity.");

    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= r_left)
        else $error("Open insert run is longer than the text left of the cursor.");

    a_unused_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.req_type > REQ_GET))
        |=> (r_state == S_IDLE) && $stable(r_left) && $stable(r_right))
        else $error("An unused request code changed the text.");
`endif

endmodule
`default_nettype wire
